// ===== sv/ptfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptfm_pkg
// Shared types and constants for the persistent threshold fault monitor.
// ----------------------------------------------------------------------------
package ptfm_pkg;

    localparam int CHANNELS        = 4;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int THRESH_WIDTH    = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int CODE_WIDTH      = 3;
    localparam int CH_IDX_WIDTH    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CURRENT_TH = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TEMP_TH    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_VIN_TH     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_VOUT_TH    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIRECTION  = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ENABLE     = 3'd6;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FORCE  = 1'b1;

    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET    = 16'h8000;
    localparam logic [CFG_WIDTH-1:0]    LIMIT_RESET     = '0;
    localparam logic [CHANNELS-1:0]     DIRECTION_RESET = '0;
    localparam logic [CHANNELS-1:0]     ENABLE_RESET    = '1;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [THRESH_WIDTH-1:0]        t_threshold;

    typedef struct packed {
        logic                    command;
        t_sample                 current_sample;
        t_sample                 temperature_sample;
        t_sample                 input_voltage_sample;
        t_sample                 output_voltage_sample;
        logic [CH_IDX_WIDTH-1:0] force_channel;
    } t_in_item;

    typedef struct packed {
        logic [CODE_WIDTH-1:0] fault_code;
        logic [CHANNELS-1:0]   fault_flags;
    } t_out_item;

    // per-lane controls from the top level
    typedef struct packed {
        logic tick;
        logic force_set;
        logic below;
    } t_lane_ctl;

endpackage

// ===== sv/ptfm_lane.sv =====
// ----------------------------------------------------------------------------
// ptfm_lane
// One channel: magnitude compare, persistence counter and fault latch.
// ----------------------------------------------------------------------------
module ptfm_lane import ptfm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lane_ctl            i_ctl,
    input  t_sample              i_sample,
    input  t_threshold           i_threshold,
    input  logic [CFG_WIDTH-1:0] i_limit,
    output logic                 o_latch_next
);

    localparam int MAG_WIDTH = SAMPLE_WIDTH + 1;
    localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_latch;
    logic [MAG_WIDTH-1:0]   sample_ext;
    logic [MAG_WIDTH-1:0]   mag;
    logic [MAG_WIDTH-1:0]   th_ext;
    logic                   hit;
    logic                   below_limit;

    assign sample_ext = {i_sample[SAMPLE_WIDTH-1], i_sample};
    // exact magnitude, most negative value included
    assign mag    = sample_ext[MAG_WIDTH-1] ? (MAG_WIDTH'(0) - sample_ext) : sample_ext;
    assign th_ext = MAG_WIDTH'(i_threshold);
    assign hit    = i_ctl.below ? (mag <= th_ext) : (mag >= th_ext);

    // limit beyond the counter range is clipped to the all-ones count
    assign below_limit = (CMP_WIDTH'(r_count) < CMP_WIDTH'(i_limit)) && !(&r_count);

    always_comb begin
        n_count      = r_count;
        o_latch_next = r_latch | i_ctl.force_set;
        if (i_ctl.tick) begin
            if (hit) begin
                if (below_limit) begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end else begin
                    o_latch_next = 1'b1;
                end
            end else begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_latch <= 1'b0;
        end else begin
            r_count <= n_count;
            r_latch <= o_latch_next;
        end
    end

endmodule

// ===== sv/persistent_threshold_fault_monitor_top.sv =====
// ----------------------------------------------------------------------------
// persistent_threshold_fault_monitor_top
// Over/under threshold fault monitor with persistence for four channels.
// ----------------------------------------------------------------------------
// Usage:
//   input channel : valid/ready; each transfer is a sample tick (all four
//                   channels checked) or a force command for one channel
//   output channel: valid/ready; exactly one result per input transfer,
//                   carrying the latched flags and the lowest enabled fault
//   config port   : write enable, index, data; write only while idle
// Result: each result is registered in the output queue before it is presented.
// Throughput: one item per cycle while the output queue is not full; the four
//   lane updates and the fault code encoder are combinational between the
//   input and the result register.
// Stall: a two-entry output queue (result register plus skid entry) lets one
//   more item in while a result waits; o_in_ready drops once both are full.
// Reset: synchronous, active low; thresholds return to 32768, limit and
//   direction mask to 0, enable mask to all ones, counters and fault latches
//   clear and the output queue empties. Latches clear only on reset.
// ----------------------------------------------------------------------------
module persistent_threshold_fault_monitor_top import ptfm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_item,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data
);

    t_threshold           r_threshold [CHANNELS];
    logic [CFG_WIDTH-1:0] r_limit;
    logic [CHANNELS-1:0]  r_direction;
    logic [CHANNELS-1:0]  r_enable;

    t_out_item            r_head, r_skid;
    logic                 r_head_valid, r_skid_valid;

    logic                 in_xfer;
    logic                 out_xfer;
    t_sample              samples     [CHANNELS];
    t_lane_ctl            lane_ctl    [CHANNELS];
    logic [CHANNELS-1:0]  latch_next;
    t_out_item            n_result;

    assign o_in_ready  = !r_skid_valid;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_head_valid;
    assign out_xfer    = r_head_valid && i_out_ready;
    assign o_out_item  = r_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_threshold[c] <= THRESH_RESET;
            end
            r_limit     <= LIMIT_RESET;
            r_direction <= DIRECTION_RESET;
            r_enable    <= ENABLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CURRENT_TH, REG_TEMP_TH, REG_VIN_TH, REG_VOUT_TH: begin
                    r_threshold[i_cfg_index[CH_IDX_WIDTH-1:0]] <= i_cfg_data;
                end
                REG_LIMIT: begin
                    r_limit <= i_cfg_data;
                end
                REG_DIRECTION: begin
                    r_direction <= i_cfg_data[CHANNELS-1:0];
                end
                REG_ENABLE: begin
                    r_enable <= i_cfg_data[CHANNELS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign samples[0] = i_in_item.current_sample;
    assign samples[1] = i_in_item.temperature_sample;
    assign samples[2] = i_in_item.input_voltage_sample;
    assign samples[3] = i_in_item.output_voltage_sample;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        assign lane_ctl[c].tick      = in_xfer && (i_in_item.command == CMD_SAMPLE);
        assign lane_ctl[c].force_set = in_xfer && (i_in_item.command == CMD_FORCE)
                                       && (i_in_item.force_channel == CH_IDX_WIDTH'(c));
        assign lane_ctl[c].below     = r_direction[c];

        ptfm_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (lane_ctl[c]),
            .i_sample     (samples[c]),
            .i_threshold  (r_threshold[c]),
            .i_limit      (r_limit),
            .o_latch_next (latch_next[c])
        );
    end

    // lowest enabled latched channel wins
    always_comb begin
        n_result.fault_flags = latch_next;
        n_result.fault_code  = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (latch_next[c] && r_enable[c]) begin
                n_result.fault_code = CODE_WIDTH'(c + 1);
            end
        end
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_xfer) begin
                if (r_skid_valid) begin
                    r_head       <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (in_xfer) begin
                    r_head <= n_result;
                end else begin
                    r_head_valid <= 1'b0;
                end
            end else if (in_xfer) begin
                if (!r_head_valid) begin
                    r_head       <= n_result;
                    r_head_valid <= 1'b1;
                end else begin
                    r_skid       <= n_result;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/ptfm_checker.sv =====
// ----------------------------------------------------------------------------
// ptfm_checker
// Port-level checks for the fault monitor, bound to the top level.
// ----------------------------------------------------------------------------
module ptfm_checker import ptfm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // the reported code is zero or names a latched channel
    a_code_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.fault_code == 3'd0)
            || (o_out_item.fault_code == 3'd1 && o_out_item.fault_flags[0])
            || (o_out_item.fault_code == 3'd2 && o_out_item.fault_flags[1])
            || (o_out_item.fault_code == 3'd3 && o_out_item.fault_flags[2])
            || (o_out_item.fault_code == 3'd4 && o_out_item.fault_flags[3]))
        else $error("fault code does not match the flags");

    // input side only blocks while a result is waiting
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // reset empties the output queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output queue not empty after reset");

endmodule

bind persistent_threshold_fault_monitor_top ptfm_checker u_ptfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
